/* rtl/rme_pkg.sv */
package rme_pkg;

    localparam int MEM_DEPTH  = 65536;
    localparam int PROG_DEPTH = 65536;
    localparam int NUM_REGS   = 8;

    localparam int MEM_AW = $clog2(MEM_DEPTH);
    localparam int REG_AW = $clog2(NUM_REGS);
    localparam int PC_W   = 16;
    localparam int LEN_W  = 17;
    localparam int VAL_W  = 64;
    localparam int COST_W = 7;

    localparam logic [COST_W-1:0] COST_IO   = COST_W'(100);
    localparam logic [COST_W-1:0] COST_MEM  = COST_W'(50);
    localparam logic [COST_W-1:0] COST_ALU  = COST_W'(5);
    localparam logic [COST_W-1:0] COST_STEP = COST_W'(1);

    typedef enum logic [3:0] {
        OP_GET   = 4'd0,
        OP_PUT   = 4'd1,
        OP_LOAD  = 4'd2,
        OP_STORE = 4'd3,
        OP_COPY  = 4'd4,
        OP_ADD   = 4'd5,
        OP_SUB   = 4'd6,
        OP_HALF  = 4'd7,
        OP_INC   = 4'd8,
        OP_DEC   = 4'd9,
        OP_JUMP  = 4'd10,
        OP_JZERO = 4'd11,
        OP_JODD  = 4'd12,
        OP_HALT  = 4'd13
    } op_t;

    typedef enum logic [1:0] {
        ST_RUN        = 2'd0,
        ST_HALT       = 2'd1,
        ST_PC_RANGE   = 2'd2,
        ST_ADDR_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic [3:0]       operation;
        logic [REG_AW-1:0] reg_x;
        logic [REG_AW-1:0] reg_y;
        logic [PC_W-1:0]  jump_target;
        logic [VAL_W-1:0] in_value;
    } instr_t;

    typedef struct packed {
        logic [PC_W-1:0]  next_pc;
        logic             put_valid;
        logic [VAL_W-1:0] put_value;
        logic [1:0]       status;
        logic [VAL_W-1:0] total_cost;
    } result_t;

endpackage

/* rtl/register_machine_executor.sv */
// register_machine_executor: executes one instruction of an eight-register
// machine per transfer on the input channel (in_valid/in_ready, in_data).
// Each transfer produces exactly one result on the output channel
// (out_valid/out_ready, out_data): next pc, optional put value, status and
// accumulated cost. cfg_wr_en/cfg_wr_data set the program length at any time.
// An accepted instruction is registered in the execute stage and its result
// in the output register; the next is taken only once it has executed. The
// register file and data memory are synchronous RAMs, so an instruction
// reads in its accept cycle and writes back in its execute cycle.
// After reset a clearing pass zeroes the data memory and the register file,
// one entry per cycle over all 65536 addresses; in_ready stays low until done.
// When the receiver stalls, the result holds in the output register, one
// more instruction may be accepted and waits in the execute stage, and
// in_ready then stays low until the output drains.
// Once status is nonzero, instructions are still taken and the result
// repeats the stopped pc, status and cost.
module register_machine_executor
    import rme_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  instr_t           in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output result_t          out_data,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data
);

    logic              clearing_reg;
    logic [MEM_AW-1:0] clr_idx_reg;
    logic              ex_valid_reg;
    instr_t            ex_instr_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [PC_W-1:0]   pc_next;
    logic [VAL_W-1:0]  cost_reg;
    logic [VAL_W-1:0]  cost_next;
    status_t           status_reg;
    status_t           status_next;
    logic [LEN_W-1:0]  prog_len_reg;
    logic [VAL_W-1:0]  a_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;
    result_t           result;

    logic              in_xfer;
    logic              ex_fire;
    logic [VAL_W-1:0]  rx;
    logic [VAL_W-1:0]  ry;
    logic [VAL_W-1:0]  md;
    logic              rf_we;
    logic [VAL_W-1:0]  rf_wdata;
    logic              dm_we;
    logic              addr_bad;
    logic              advance;
    logic [COST_W-1:0] cost_add;
    logic [LEN_W-1:0]  npc;
    logic [LEN_W-1:0]  limit;
    logic [VAL_W:0]    diff;
    logic              clr_rf;

    logic              rf_wr_en;
    logic [REG_AW-1:0] rf_wr_addr;
    logic [VAL_W-1:0]  rf_wr_data;
    logic              dm_wr_en;
    logic [MEM_AW-1:0] dm_wr_addr;
    logic [VAL_W-1:0]  dm_wr_data;

    assign in_ready  = !clearing_reg && !ex_valid_reg;
    assign in_xfer   = in_valid && in_ready;
    assign ex_fire   = ex_valid_reg && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // register file, one copy per read port
    assign clr_rf     = clearing_reg && (clr_idx_reg < MEM_AW'(NUM_REGS));
    assign rf_wr_en   = clearing_reg ? clr_rf : (ex_fire && rf_we);
    assign rf_wr_addr = clearing_reg ? clr_idx_reg[REG_AW-1:0] : ex_instr_reg.reg_x;
    assign rf_wr_data = clearing_reg ? '0 : rf_wdata;

    assign dm_wr_en   = clearing_reg || (ex_fire && dm_we);
    assign dm_wr_addr = clearing_reg ? clr_idx_reg : a_reg[MEM_AW-1:0];
    assign dm_wr_data = clearing_reg ? '0 : rx;

    rme_ram #(.ADDR_W(REG_AW), .DATA_W(VAL_W)) u_rf_x (
        .clk     (clk),
        .wr_en   (rf_wr_en),
        .wr_addr (rf_wr_addr),
        .wr_data (rf_wr_data),
        .rd_en   (in_xfer),
        .rd_addr (in_data.reg_x),
        .rd_data (rx)
    );

    rme_ram #(.ADDR_W(REG_AW), .DATA_W(VAL_W)) u_rf_y (
        .clk     (clk),
        .wr_en   (rf_wr_en),
        .wr_addr (rf_wr_addr),
        .wr_data (rf_wr_data),
        .rd_en   (in_xfer),
        .rd_addr (in_data.reg_y),
        .rd_data (ry)
    );

    rme_ram #(.ADDR_W(MEM_AW), .DATA_W(VAL_W)) u_dmem (
        .clk     (clk),
        .wr_en   (dm_wr_en),
        .wr_addr (dm_wr_addr),
        .wr_data (dm_wr_data),
        .rd_en   (in_xfer),
        .rd_addr (a_reg[MEM_AW-1:0]),
        .rd_data (md)
    );

    assign addr_bad = |a_reg[VAL_W-1:MEM_AW];

    // execute stage
    always_comb
    begin
        diff        = {1'b0, rx} - {1'b0, ry};
        limit       = (prog_len_reg > LEN_W'(PROG_DEPTH)) ? LEN_W'(PROG_DEPTH) : prog_len_reg;
        npc         = LEN_W'(pc_reg) + LEN_W'(1);
        rf_we       = 1'b0;
        rf_wdata    = rx;
        dm_we       = 1'b0;
        cost_add    = '0;
        advance     = 1'b0;
        status_next = status_reg;
        pc_next     = pc_reg;
        cost_next   = cost_reg;

        result.next_pc   = pc_reg;
        result.put_valid = 1'b0;
        result.put_value = '0;

        if (status_reg == ST_RUN)
        begin
            if ((ex_instr_reg.operation == OP_LOAD || ex_instr_reg.operation == OP_STORE)
                && addr_bad)
            begin
                status_next = ST_ADDR_RANGE;
            end
            else
            begin
                unique case (ex_instr_reg.operation)
                    OP_GET:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = ex_instr_reg.in_value;
                        cost_add = COST_IO;
                        advance  = 1'b1;
                    end
                    OP_PUT:
                    begin
                        result.put_valid = 1'b1;
                        result.put_value = rx;
                        cost_add = COST_IO;
                        advance  = 1'b1;
                    end
                    OP_LOAD:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = md;
                        cost_add = COST_MEM;
                        advance  = 1'b1;
                    end
                    OP_STORE:
                    begin
                        dm_we    = 1'b1;
                        cost_add = COST_MEM;
                        advance  = 1'b1;
                    end
                    OP_COPY:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = ry;
                        cost_add = COST_ALU;
                        advance  = 1'b1;
                    end
                    OP_ADD:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = rx + ry;
                        cost_add = COST_ALU;
                        advance  = 1'b1;
                    end
                    OP_SUB:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = diff[VAL_W] ? '0 : diff[VAL_W-1:0];
                        cost_add = COST_ALU;
                        advance  = 1'b1;
                    end
                    OP_HALF:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = rx >> 1;
                        cost_add = COST_STEP;
                        advance  = 1'b1;
                    end
                    OP_INC:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = rx + VAL_W'(1);
                        cost_add = COST_STEP;
                        advance  = 1'b1;
                    end
                    OP_DEC:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = (rx != '0) ? rx - VAL_W'(1) : '0;
                        cost_add = COST_STEP;
                        advance  = 1'b1;
                    end
                    OP_JUMP:
                    begin
                        npc      = LEN_W'(ex_instr_reg.jump_target);
                        cost_add = COST_STEP;
                        advance  = 1'b1;
                    end
                    OP_JZERO:
                    begin
                        if (rx == '0)
                        begin
                            npc = LEN_W'(ex_instr_reg.jump_target);
                        end
                        cost_add = COST_STEP;
                        advance  = 1'b1;
                    end
                    OP_JODD:
                    begin
                        if (rx[0])
                        begin
                            npc = LEN_W'(ex_instr_reg.jump_target);
                        end
                        cost_add = COST_STEP;
                        advance  = 1'b1;
                    end
                    OP_HALT:
                    begin
                        status_next = ST_HALT;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (advance)
            begin
                cost_next      = cost_reg + VAL_W'(cost_add);
                result.next_pc = npc[PC_W-1:0];
                if (npc >= limit)
                begin
                    status_next = ST_PC_RANGE;
                end
                else
                begin
                    pc_next = npc[PC_W-1:0];
                end
            end
        end

        result.status     = status_next;
        result.total_cost = cost_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            prog_len_reg  <= LEN_W'(PROG_DEPTH);
            ex_valid_reg  <= 1'b0;
            pc_reg        <= '0;
            cost_reg      <= '0;
            status_reg    <= ST_RUN;
            a_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + MEM_AW'(1);
                if (&clr_idx_reg)
                begin
                    clearing_reg <= 1'b0;
                end
            end

            if (cfg_wr_en)
            begin
                prog_len_reg <= cfg_wr_data;
            end

            if (in_xfer)
            begin
                ex_valid_reg <= 1'b1;
            end
            else if (ex_fire)
            begin
                ex_valid_reg <= 1'b0;
            end

            if (ex_fire)
            begin
                pc_reg     <= pc_next;
                cost_reg   <= cost_next;
                status_reg <= status_next;
                if (rf_we && ex_instr_reg.reg_x == '0)
                begin
                    a_reg <= rf_wdata;
                end
            end

            if (ex_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ex_instr_reg <= in_data;
        end
        if (ex_fire)
        begin
            out_data_reg <= result;
        end
    end

endmodule

/* rtl/rme_ram.sv */
module rme_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 64
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/rme_checker.sv */
module rme_checker
    import rme_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input instr_t           in_data,
    input logic             out_valid,
    input logic             out_ready,
    input result_t          out_data
);

    // an instruction waiting for transfer holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input changed while waiting");

    // a result waiting for transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // one instruction in flight between accept and execute
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

    // a fresh result comes from an earlier transfer
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching input transfer");

    // halted or address fault never emits a put value
    a_no_put_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_HALT || out_data.status == ST_ADDR_RANGE)
        |-> !out_data.put_valid && out_data.put_value == '0)
        else $error("put value with stopped status");

endmodule

bind register_machine_executor rme_checker u_rme_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
);

/* test/tb_register_machine_executor.sv */
`timescale 1ns / 1ps

module tb_register_machine_executor;
    import rme_pkg::*;

    localparam logic [3:0] OP_UNUSED_LO = 4'd14;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 190;
    localparam int SETTLE_CYCLES = 8;

    typedef enum int {
        STOP_HALT,
        STOP_ADDR,
        STOP_PC_JUMP,
        STOP_SHORT_PROGRAM
    } stop_kind_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    instr_t           in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    result_t          out_data;
    logic             cfg_wr_en = 1'b0;
    logic [LEN_W-1:0] cfg_wr_data = '0;

    // machine state as predicted
    bit [VAL_W-1:0]   machine_regs [NUM_REGS];
    bit [VAL_W-1:0]   machine_mem [MEM_DEPTH];
    logic [PC_W-1:0]  machine_pc = '0;
    logic [VAL_W-1:0] machine_cost = '0;
    status_t          machine_status = ST_RUN;
    logic [LEN_W-1:0] program_len = LEN_W'(PROG_DEPTH);

    instr_t  pending_instrs [$];
    result_t predicted_results [$];

    int  send_gap = 0;
    int  stall_left = 0;
    bit  no_idle = 1'b0;
    int  instrs_queued = 0;
    int  instrs_sent = 0;
    int  results_seen = 0;
    int  length_writes = 0;
    int  mismatches = 0;
    int  cycle_count = 0;

    register_machine_executor i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [LEN_W-1:0] pc_limit();
        return (program_len > PROG_DEPTH) ? LEN_W'(PROG_DEPTH) : program_len;
    endfunction

    function automatic result_t execute_instruction(instr_t ins);
        result_t          res;
        logic [LEN_W-1:0] npc;
        logic [VAL_W-1:0] vx;
        logic [VAL_W-1:0] vy;
        logic [VAL_W-1:0] charge;
        bit               ran;
        res = '0;
        npc = LEN_W'(machine_pc) + 1'b1;
        vx = machine_regs[ins.reg_x];
        vy = machine_regs[ins.reg_y];
        charge = '0;
        ran = 1'b0;
        if (machine_status == ST_RUN)
        begin
            if ((ins.operation == OP_LOAD || ins.operation == OP_STORE)
                    && machine_regs[0] >= MEM_DEPTH)
                machine_status = ST_ADDR_RANGE;
            else if (ins.operation == OP_HALT)
                machine_status = ST_HALT;
            else if (ins.operation < OP_HALT)
            begin
                ran = 1'b1;
                case (ins.operation)
                    OP_GET:
                    begin
                        machine_regs[ins.reg_x] = ins.in_value;
                        charge = COST_IO;
                    end
                    OP_PUT:
                    begin
                        res.put_valid = 1'b1;
                        res.put_value = vx;
                        charge = COST_IO;
                    end
                    OP_LOAD:
                    begin
                        machine_regs[ins.reg_x] = machine_mem[machine_regs[0][MEM_AW-1:0]];
                        charge = COST_MEM;
                    end
                    OP_STORE:
                    begin
                        machine_mem[machine_regs[0][MEM_AW-1:0]] = vx;
                        charge = COST_MEM;
                    end
                    OP_COPY:
                    begin
                        machine_regs[ins.reg_x] = vy;
                        charge = COST_ALU;
                    end
                    OP_ADD:
                    begin
                        machine_regs[ins.reg_x] = vx + vy;
                        charge = COST_ALU;
                    end
                    OP_SUB:
                    begin
                        machine_regs[ins.reg_x] = (vx >= vy) ? vx - vy : '0;
                        charge = COST_ALU;
                    end
                    OP_HALF:
                    begin
                        machine_regs[ins.reg_x] = vx >> 1;
                        charge = COST_STEP;
                    end
                    OP_INC:
                    begin
                        machine_regs[ins.reg_x] = vx + 1'b1;
                        charge = COST_STEP;
                    end
                    OP_DEC:
                    begin
                        machine_regs[ins.reg_x] = (vx != '0) ? vx - 1'b1 : '0;
                        charge = COST_STEP;
                    end
                    OP_JUMP:
                    begin
                        npc = LEN_W'(ins.jump_target);
                        charge = COST_STEP;
                    end
                    OP_JZERO:
                    begin
                        if (vx == '0)
                            npc = LEN_W'(ins.jump_target);
                        charge = COST_STEP;
                    end
                    OP_JODD:
                    begin
                        if (vx[0])
                            npc = LEN_W'(ins.jump_target);
                        charge = COST_STEP;
                    end
                    default: ;
                endcase
                machine_cost += charge;
                if (npc >= pc_limit())
                    machine_status = ST_PC_RANGE;
                else
                    machine_pc = npc[PC_W-1:0];
            end
        end
        res.next_pc = ran ? npc[PC_W-1:0] : machine_pc;
        res.status = machine_status;
        res.total_cost = machine_cost;
        return res;
    endfunction

    function automatic instr_t make_instr(logic [3:0] op, logic [REG_AW-1:0] x,
                                          logic [REG_AW-1:0] y, logic [PC_W-1:0] target,
                                          logic [VAL_W-1:0] value);
        instr_t ins;
        ins.operation = op;
        ins.reg_x = x;
        ins.reg_y = y;
        ins.jump_target = target;
        ins.in_value = value;
        return ins;
    endfunction

    function automatic void queue_instruction(instr_t ins);
        pending_instrs.push_back(ins);
        predicted_results.push_back(execute_instruction(ins));
        instrs_queued++;
    endfunction

    // register A mostly gets usable addresses, small ones to make memory hits repeat
    function automatic logic [VAL_W-1:0] random_value(logic [REG_AW-1:0] dst);
        if (dst == '0 && $urandom_range(0, 3) != 0)
            return $urandom_range(0, 1) ? VAL_W'($urandom_range(0, 15))
                                        : VAL_W'($urandom_range(0, MEM_DEPTH - 1));
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return VAL_W'($urandom_range(0, 15));
            3: return ~VAL_W'($urandom_range(0, 15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // random instruction that keeps the machine running
    function automatic instr_t random_running_instr();
        instr_t           ins;
        logic [LEN_W-1:0] lim;
        lim = pc_limit();
        if ($urandom_range(0, 31) == 0)
            ins.operation = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        else
            ins.operation = 4'($urandom_range(OP_GET, OP_JODD));
        ins.reg_x = REG_AW'($urandom);
        ins.reg_y = REG_AW'($urandom);
        ins.jump_target = PC_W'($urandom);
        ins.in_value = random_value(ins.reg_x);
        if ((ins.operation == OP_LOAD || ins.operation == OP_STORE)
                && machine_regs[0] >= MEM_DEPTH)
        begin
            ins.operation = OP_GET;
            ins.reg_x = '0;
            ins.in_value = VAL_W'($urandom_range(0, MEM_DEPTH - 1));
        end
        if (ins.operation == OP_JUMP || ins.operation == OP_JZERO || ins.operation == OP_JODD)
            ins.jump_target = PC_W'($urandom_range(0, lim - 1));
        if (ins.operation != OP_JUMP && LEN_W'(machine_pc) + 1'b1 >= lim)
        begin
            ins.operation = OP_JUMP;
            ins.jump_target = PC_W'($urandom_range(0, lim - 1));
        end
        return ins;
    endfunction

    task automatic write_length(logic [LEN_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        program_len = value;
        length_writes++;
    endtask

    task automatic wait_drained();
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic compare_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(result_t got);
        result_t want;
        results_seen++;
        if (predicted_results.size() == 0)
        begin
            $error("result transfer with nothing predicted: next_pc 0x%0h", got.next_pc);
            mismatches++;
        end
        else
        begin
            want = predicted_results.pop_front();
            compare_field("next_pc", want.next_pc, got.next_pc);
            compare_field("put_valid", want.put_valid, got.put_valid);
            compare_field("put_value", want.put_value, got.put_value);
            compare_field("status", want.status, got.status);
            compare_field("total_cost", want.total_cost, got.total_cost);
        end
    endtask

    // instruction driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                instrs_sent++;
            if (send_gap != 0 && !no_idle)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_instrs.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data <= pending_instrs.pop_front();
                if (!no_idle && $urandom_range(0, 9) == 0)
                    send_gap <= $urandom_range(1, 19);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            if (stall_left != 0 && !no_idle)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 15) == 0)
            begin
                stall_left <= $urandom_range(0, 18);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, predicted_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        stop_kind_t       stop_kind;
        logic [LEN_W-1:0] lengths [$];

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        write_length(LEN_W'(PROG_DEPTH));
        queue_instruction(make_instr(OP_GET, 1, 0, '0, '1));
        queue_instruction(make_instr(OP_GET, 2, 7, '1, '0));
        queue_instruction(make_instr(OP_PUT, 1, 0, '0, '0));
        queue_instruction(make_instr(OP_ADD, 1, 1, '0, '0));
        queue_instruction(make_instr(OP_GET, 3, 0, '0, '1));
        queue_instruction(make_instr(OP_INC, 3, 0, '0, '0));
        queue_instruction(make_instr(OP_DEC, 2, 0, '0, '0));
        queue_instruction(make_instr(OP_GET, 4, 0, '0, 64'd5));
        queue_instruction(make_instr(OP_SUB, 2, 4, '0, '0));
        queue_instruction(make_instr(OP_SUB, 1, 4, '0, '0));
        queue_instruction(make_instr(OP_HALF, 1, 0, '0, '0));
        queue_instruction(make_instr(OP_COPY, 5, 1, '0, '0));
        queue_instruction(make_instr(OP_GET, 0, 0, '0, VAL_W'(MEM_DEPTH - 1)));
        queue_instruction(make_instr(OP_STORE, 5, 0, '0, '0));
        queue_instruction(make_instr(OP_LOAD, 6, 0, '0, '0));
        queue_instruction(make_instr(OP_GET, 0, 0, '0, '0));
        queue_instruction(make_instr(OP_LOAD, 7, 0, '0, '0));
        queue_instruction(make_instr(OP_JZERO, 2, 0, '1, '0));
        queue_instruction(make_instr(OP_JUMP, 0, 0, '0, '0));
        queue_instruction(make_instr(OP_JODD, 1, 0, 16'd9, '0));
        queue_instruction(make_instr(OP_INC, 3, 0, '0, '0));
        queue_instruction(make_instr(OP_JODD, 3, 0, 16'd40, '0));
        queue_instruction(make_instr(OP_JZERO, 3, 0, 16'd2, '0));
        queue_instruction(make_instr(OP_UNUSED_LO, 7, 7, '1, '1));
        queue_instruction(make_instr(OP_UNUSED_HI, 0, 0, '0, '0));
        queue_instruction(make_instr(OP_PUT, 6, 5, '1, '1));
        wait_drained();

        // random phases over several program lengths
        lengths = '{'1, LEN_W'($urandom_range(16, 300)), LEN_W'(2),
                    LEN_W'($urandom_range(301, PROG_DEPTH - 1)), LEN_W'(PROG_DEPTH)};
        foreach (lengths[i])
        begin
            write_length(lengths[i]);
            repeat (PHASE_ITEMS) queue_instruction(random_running_instr());
            wait_drained();
        end

        // final phase: no idling, stop the machine one way, then feed it more
        no_idle = 1'b1;
        stop_kind = stop_kind_t'($urandom_range(STOP_HALT, STOP_SHORT_PROGRAM));
        case (stop_kind)
            STOP_HALT: write_length(LEN_W'(PROG_DEPTH));
            STOP_ADDR: write_length('1);
            STOP_PC_JUMP: write_length(LEN_W'($urandom_range(16, PROG_DEPTH - 1)));
            default: write_length(LEN_W'($urandom_range(0, 1)));
        endcase
        if (stop_kind != STOP_SHORT_PROGRAM)
            repeat (40) queue_instruction(random_running_instr());
        case (stop_kind)
            STOP_HALT:
                queue_instruction(make_instr(OP_HALT, REG_AW'($urandom), REG_AW'($urandom),
                                             PC_W'($urandom), {$urandom, $urandom}));
            STOP_ADDR:
            begin
                queue_instruction(make_instr(OP_GET, 0, 0, '0,
                    $urandom_range(0, 1) ? VAL_W'(MEM_DEPTH)
                                         : ({$urandom, $urandom} | VAL_W'(MEM_DEPTH))));
                queue_instruction(make_instr($urandom_range(0, 1) ? OP_LOAD : OP_STORE,
                                             REG_AW'($urandom), '0, '0, '0));
            end
            STOP_PC_JUMP:
            begin
                queue_instruction(make_instr(OP_JUMP, 0, 0, PC_W'(pc_limit() - 1), '0));
                queue_instruction(make_instr(OP_PUT, REG_AW'($urandom), '0, '0, '0));
            end
            default:
                queue_instruction(make_instr(4'($urandom_range(OP_GET, OP_JODD)),
                                             REG_AW'($urandom), REG_AW'($urandom),
                                             PC_W'($urandom), {$urandom, $urandom}));
        endcase
        repeat (12)
            queue_instruction(make_instr(4'($urandom_range(OP_GET, OP_UNUSED_HI)),
                                         REG_AW'($urandom), REG_AW'($urandom),
                                         PC_W'($urandom), {$urandom, $urandom}));
        wait_drained();

        $display("%0d instructions sent over %0d program length settings, %0d results checked",
                 instrs_sent, length_writes, results_seen);
        $display("machine ended in %s at pc 0x%0h with cost %0d, %0d mismatches",
                 machine_status.name(), machine_pc, machine_cost, mismatches);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/rme_pkg.sv
rtl/rme_ram.sv
rtl/register_machine_executor.sv
rtl/rme_checker.sv
test/tb_register_machine_executor.sv
